### rtl/core/wti_pkg.sv
package wti_pkg;

	// Value layout of one table row: position x/y/z, velocity x/y/z, fuel mass.
	localparam int unsigned VAL_W     = 32;
	localparam int unsigned NUM_VALS  = 7;
	localparam int unsigned VAL_IDX_W = 3;
	localparam int unsigned ROW_W     = VAL_W * NUM_VALS;
	localparam int unsigned RATIO_W   = 16;
	localparam int unsigned PIU_W     = 5;

	localparam logic [PIU_W-1:0] PIU_RESET = 5'd10;
	localparam logic [PIU_W-1:0] PIU_MIN   = 5'd2;

	localparam logic [VAL_IDX_W-1:0] VAL_IDX_LAST = 3'(NUM_VALS - 1);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		STATUS_INTERP = 2'd0,
		STATUS_FIRST  = 2'd1,
		STATUS_LAST   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_ROW_A,
		ST_ROW_B,
		ST_ROW_C,
		ST_DIV_WAIT,
		ST_LERP,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic               operation;
		logic [3:0]         point_index;
		logic [31:0]        point_time;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] fuel_mass;
		logic [31:0]        query_time;
	} request_t;

	typedef struct packed {
		logic [31:0]        out_time;
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_pos_z;
		logic signed [31:0] out_vel_x;
		logic signed [31:0] out_vel_y;
		logic signed [31:0] out_vel_z;
		logic signed [31:0] out_fuel_mass;
		status_t            status;
	} response_t;

endpackage

### rtl/core/wti_table.sv
module wti_table #(
	parameter int unsigned MAX_POINTS = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [$clog2(MAX_POINTS)-1:0]             waddr,
	input  logic [wti_pkg::VAL_W-1:0]                 wtime,
	input  logic [wti_pkg::ROW_W-1:0]                 wrow,
	input  logic [$clog2(MAX_POINTS)-1:0]             traddr,
	output logic [wti_pkg::VAL_W-1:0]                 trdata,
	input  logic [$clog2(MAX_POINTS)-1:0]             vraddr,
	output logic [wti_pkg::ROW_W-1:0]                 vrdata
);

	logic [wti_pkg::VAL_W-1:0] time_mem [MAX_POINTS];
	logic [wti_pkg::ROW_W-1:0] row_mem  [MAX_POINTS];

	// Time memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			time_mem[waddr] <= wtime;
		end
		trdata <= time_mem[traddr];
	end

	// Value memory: all seven values of a point share one row.
	always_ff @(posedge clk) begin
		if (we) begin
			row_mem[waddr] <= wrow;
		end
		vrdata <= row_mem[vraddr];
	end

endmodule

### rtl/core/wti_divider.sv
module wti_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wti_pkg::VAL_W-1:0]   dividend,
	input  logic [wti_pkg::VAL_W-1:0]   divisor,
	output logic                        busy,
	output logic [wti_pkg::RATIO_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(wti_pkg::RATIO_W);

	logic                        busy_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [wti_pkg::VAL_W-1:0]   rem_q;
	logic [wti_pkg::VAL_W-1:0]   dsr_q;
	logic [wti_pkg::RATIO_W-1:0] quo_q;
	logic [wti_pkg::VAL_W:0]     shifted;
	logic [wti_pkg::VAL_W:0]     diff;
	logic                        take;

	// One restoring step: the remainder always stays below the divisor.
	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, dsr_q};
	assign take    = shifted >= {1'b0, dsr_q};

	// Step counter, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(wti_pkg::RATIO_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[wti_pkg::VAL_W-1:0] : shifted[wti_pkg::VAL_W-1:0];
			quo_q <= {quo_q[wti_pkg::RATIO_W-2:0], take};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

### rtl/core/wti_lerp.sv
module wti_lerp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [wti_pkg::VAL_IDX_W-1:0] in_idx,
	input  logic [wti_pkg::VAL_W-1:0]     v0,
	input  logic [wti_pkg::VAL_W-1:0]     v1,
	input  logic [wti_pkg::RATIO_W-1:0]   ratio,
	output logic                          out_valid,
	output logic [wti_pkg::VAL_IDX_W-1:0] out_idx,
	output logic [wti_pkg::VAL_W-1:0]     value
);

	localparam int unsigned DIFF_W = wti_pkg::VAL_W + 1;
	localparam int unsigned PROD_W = DIFF_W + wti_pkg::RATIO_W + 1;

	logic signed [DIFF_W-1:0]      diff;
	logic signed [PROD_W-1:0]      prod;
	logic signed [PROD_W-1:0]      prod_s1;
	logic [wti_pkg::VAL_W-1:0]     v0_s1;
	logic [wti_pkg::VAL_IDX_W-1:0] idx_s1;
	logic                          vld_s1;
	logic [wti_pkg::VAL_W-1:0]     value_s2;
	logic [wti_pkg::VAL_IDX_W-1:0] idx_s2;
	logic                          vld_s2;

	// Stage 1: exact difference times the unsigned ratio.
	assign diff = $signed({v1[wti_pkg::VAL_W-1], v1}) - $signed({v0[wti_pkg::VAL_W-1], v0});
	assign prod = $signed({1'b0, ratio}) * diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 2: dropping the low fraction bits of a two's complement product floors it.
	always_ff @(posedge clk) begin
		prod_s1  <= prod;
		v0_s1    <= v0;
		idx_s1   <= in_idx;
		value_s2 <= v0_s1 + prod_s1[wti_pkg::VAL_W+wti_pkg::RATIO_W-1:wti_pkg::RATIO_W];
		idx_s2   <= idx_s1;
	end

	assign out_valid = vld_s2;
	assign out_idx   = idx_s2;
	assign value     = value_s2;

endmodule

### rtl/core/waypoint_table_interpolator.sv
// Piecewise linear lookup over a table of trajectory points held in two
// synchronous memories, each with one write and one read port (times, and
// rows of seven values). A write item is stored on acceptance and leaves busy
// low. A query scans the time memory one point per cycle, reads the two
// neighboring rows, runs a 16-step serial divider for the ratio and then
// interpolates the seven values through one shared multiplier, one value per
// cycle. A query clamped to the first point, or past the last searched point,
// skips the divider. The result appears for exactly one cycle with done high;
// it cannot be held, so the receiver must take it then. A new item can be
// accepted in the cycle that shows the result. Configuration is accepted
// whenever the block is not busy.
module waypoint_table_interpolator #(
	parameter int unsigned MAX_POINTS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  wti_pkg::request_t                request,
	output wti_pkg::response_t               response,
	output logic                             done,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wti_pkg::PIU_W-1:0]        cfg_data
);

	localparam int unsigned IDX_W = $clog2(MAX_POINTS);

	wti_pkg::state_t               state_q, state_d;
	logic [wti_pkg::PIU_W-1:0]     piu_q;
	logic [IDX_W-1:0]              nlast_c, nlast_q;
	logic [wti_pkg::VAL_W-1:0]     q_q;
	logic [IDX_W-1:0]              iss_idx_q;
	logic                          iss_done_q;
	logic                          chk_vld_q;
	logic [IDX_W-1:0]              chk_idx_q;
	logic [wti_pkg::VAL_W-1:0]     prev_time_q;
	logic [IDX_W-1:0]              slot_a_q, slot_b_q;
	wti_pkg::status_t              status_q;
	logic [wti_pkg::RATIO_W-1:0]   ratio_q;
	logic [wti_pkg::VAL_IDX_W-1:0] k_q;
	logic [wti_pkg::ROW_W-1:0]     row_a_q, row_b_q;
	logic [wti_pkg::VAL_W-1:0]     vals_q [wti_pkg::NUM_VALS];
	logic                          done_q;

	logic                          accept, accept_query, wr_en, issue, hit, past_end;
	logic                          div_start, lerp_in_vld, finish;
	logic [IDX_W-1:0]              vraddr;
	logic [wti_pkg::VAL_W-1:0]     trdata;
	logic [wti_pkg::ROW_W-1:0]     vrdata, wrow;
	logic                          div_busy;
	logic [wti_pkg::RATIO_W-1:0]   div_quo;
	logic                          lerp_out_vld;
	logic [wti_pkg::VAL_IDX_W-1:0] lerp_out_idx;
	logic [wti_pkg::VAL_W-1:0]     lerp_value;

	// Configuration register.
	assign cfg_ready = (state_q == wti_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piu_q <= wti_pkg::PIU_RESET;
		end else if (cfg_valid && cfg_ready) begin
			piu_q <= cfg_data;
		end
	end

	// Index of the last searched point, with the register clamped to its range.
	always_comb begin
		if (piu_q < wti_pkg::PIU_MIN) begin
			nlast_c = IDX_W'(1);
		end else if (32'(piu_q) > MAX_POINTS) begin
			nlast_c = IDX_W'(MAX_POINTS - 1);
		end else begin
			nlast_c = IDX_W'(piu_q - 5'd1);
		end
	end

	// Table memories.
	assign wrow = {request.fuel_mass, request.vel_z, request.vel_y, request.vel_x,
		request.pos_z, request.pos_y, request.pos_x};
	assign vraddr = (state_q == wti_pkg::ST_ROW_A) ? slot_a_q : slot_b_q;

	wti_table #(
		.MAX_POINTS(MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (IDX_W'(request.point_index)),
		.wtime (request.point_time),
		.wrow  (wrow),
		.traddr(iss_idx_q),
		.trdata(trdata),
		.vraddr(vraddr),
		.vrdata(vrdata)
	);

	// Ratio divider: (q - t0) / (t1 - t0) as a 16-bit fraction.
	wti_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(q_q - prev_time_q),
		.divisor (trdata - prev_time_q),
		.busy    (div_busy),
		.quotient(div_quo)
	);

	// Shared interpolation pipeline.
	wti_lerp u_lerp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (lerp_in_vld),
		.in_idx   (k_q),
		.v0       (row_a_q[k_q*wti_pkg::VAL_W +: wti_pkg::VAL_W]),
		.v1       (row_b_q[k_q*wti_pkg::VAL_W +: wti_pkg::VAL_W]),
		.ratio    (ratio_q),
		.out_valid(lerp_out_vld),
		.out_idx  (lerp_out_idx),
		.value    (lerp_value)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wti_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control strobes.
	always_comb begin
		state_d      = state_q;
		accept       = 1'b0;
		accept_query = 1'b0;
		wr_en        = 1'b0;
		issue        = 1'b0;
		hit          = 1'b0;
		past_end     = 1'b0;
		div_start    = 1'b0;
		lerp_in_vld  = 1'b0;
		finish       = 1'b0;
		case (state_q)
			wti_pkg::ST_IDLE: begin
				accept = start;
				if (accept && request.operation == wti_pkg::OP_QUERY) begin
					accept_query = 1'b1;
					state_d      = wti_pkg::ST_SEARCH;
				end
				wr_en = accept && request.operation == wti_pkg::OP_WRITE &&
					32'(request.point_index) < MAX_POINTS;
			end
			wti_pkg::ST_SEARCH: begin
				issue = !iss_done_q;
				if (chk_vld_q) begin
					if (trdata > q_q) begin
						hit       = 1'b1;
						div_start = (chk_idx_q != '0);
						state_d   = wti_pkg::ST_ROW_A;
					end else if (chk_idx_q == nlast_q) begin
						past_end = 1'b1;
						state_d  = wti_pkg::ST_ROW_A;
					end
				end
			end
			wti_pkg::ST_ROW_A: begin
				state_d = wti_pkg::ST_ROW_B;
			end
			wti_pkg::ST_ROW_B: begin
				state_d = wti_pkg::ST_ROW_C;
			end
			wti_pkg::ST_ROW_C: begin
				state_d = wti_pkg::ST_DIV_WAIT;
			end
			wti_pkg::ST_DIV_WAIT: begin
				if (!div_busy) begin
					state_d = wti_pkg::ST_LERP;
				end
			end
			wti_pkg::ST_LERP: begin
				lerp_in_vld = 1'b1;
				if (k_q == wti_pkg::VAL_IDX_LAST) begin
					state_d = wti_pkg::ST_DRAIN;
				end
			end
			wti_pkg::ST_DRAIN: begin
				if (lerp_out_vld && lerp_out_idx == wti_pkg::VAL_IDX_LAST) begin
					finish  = 1'b1;
					state_d = wti_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wti_pkg::ST_IDLE;
			end
		endcase
	end

	// Search pipeline control: the read issued in one cycle is compared in the next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_done_q <= 1'b0;
			chk_vld_q  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			chk_vld_q <= issue;
			done_q    <= finish;
			if (accept_query) begin
				iss_done_q <= 1'b0;
			end else if (issue) begin
				iss_done_q <= (iss_idx_q == nlast_q);
			end
		end
	end

	// Query datapath registers.
	always_ff @(posedge clk) begin
		if (accept_query) begin
			q_q       <= request.query_time;
			nlast_q   <= nlast_c;
			iss_idx_q <= '0;
			k_q       <= '0;
		end
		if (issue) begin
			iss_idx_q <= iss_idx_q + 1'b1;
		end
		chk_idx_q <= iss_idx_q;

		// Outcome of the scan picks the two rows and the kind of result.
		if (hit) begin
			if (chk_idx_q == '0) begin
				slot_a_q <= '0;
				slot_b_q <= '0;
				status_q <= wti_pkg::STATUS_FIRST;
			end else begin
				slot_a_q <= chk_idx_q - 1'b1;
				slot_b_q <= chk_idx_q;
				status_q <= wti_pkg::STATUS_INTERP;
			end
		end else if (past_end) begin
			slot_a_q <= nlast_q;
			slot_b_q <= nlast_q;
			status_q <= wti_pkg::STATUS_LAST;
		end else if (state_q == wti_pkg::ST_SEARCH && chk_vld_q) begin
			prev_time_q <= trdata;
		end

		if (state_q == wti_pkg::ST_ROW_B) begin
			row_a_q <= vrdata;
		end
		if (state_q == wti_pkg::ST_ROW_C) begin
			row_b_q <= vrdata;
		end

		// A clamped result uses a zero ratio, which returns the row unchanged.
		if (state_q == wti_pkg::ST_DIV_WAIT && !div_busy) begin
			ratio_q <= (status_q == wti_pkg::STATUS_INTERP) ? div_quo : '0;
		end
		if (lerp_in_vld) begin
			k_q <= k_q + 1'b1;
		end
		if (lerp_out_vld) begin
			vals_q[lerp_out_idx] <= lerp_value;
		end
	end

	// Result ports.
	assign busy                   = (state_q != wti_pkg::ST_IDLE);
	assign done                   = done_q;
	assign response.out_time      = q_q;
	assign response.out_pos_x     = vals_q[0];
	assign response.out_pos_y     = vals_q[1];
	assign response.out_pos_z     = vals_q[2];
	assign response.out_vel_x     = vals_q[3];
	assign response.out_vel_y     = vals_q[4];
	assign response.out_vel_z     = vals_q[5];
	assign response.out_fuel_mass = vals_q[6];
	assign response.status        = status_q;

endmodule

### rtl/core/wti_checker.sv
module wti_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input wti_pkg::request_t         request,
	input wti_pkg::response_t        response,
	input logic                      done,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic [wti_pkg::PIU_W-1:0] cfg_data
);

	logic q_acc, w_acc;

	assign q_acc = start && !busy && request.operation == wti_pkg::OP_QUERY;
	assign w_acc = start && !busy && request.operation == wti_pkg::OP_WRITE;

	// A result strobe lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// A result only ends a query that kept the block busy.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result without a preceding busy query");

	// An accepted query makes the block busy.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_acc |=> busy)
		else $error("query accepted but block not busy");

	// A write item completes at once and gives no result.
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		w_acc |=> (!busy && !done))
		else $error("write item caused busy or a result");

	// Configuration is only taken while no query is in progress.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> !busy)
		else $error("configuration written while busy");

endmodule

bind waypoint_table_interpolator wti_checker u_wti_checker (.*);
